@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/dpwg_pkg.sv @@
package dpwg_pkg;

    localparam int MAX_BYTES = 8;
    localparam int IDX_W     = $clog2(MAX_BYTES);
    localparam int LEN_W     = $clog2(MAX_BYTES + 1);
    localparam int PRE_W     = 7;
    localparam int FILL_W    = 24;

    localparam logic [PRE_W-1:0]  PREAMBLE_RST = 7'd17;
    localparam logic [FILL_W-1:0] FILLER_RST   = 24'hFF00FF;
    localparam logic [LEN_W-1:0]  FILLER_LEN   = LEN_W'(3);
    // Start bit plus eight data bits: the last bit slot of a byte is index 8.
    localparam logic [3:0]        LAST_BIT_IDX = 4'd8;

    typedef logic [MAX_BYTES-1:0][7:0] t_buf;

    localparam t_buf SEND_BUF_RST = t_buf'({FILLER_RST[7:0], FILLER_RST[15:8],
                                            FILLER_RST[23:16]});

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef enum logic {
        CFG_PREAMBLE = 1'b0,
        CFG_FILLER   = 1'b1
    } t_cfg_idx;

    // Pending packet status handed from the loader to the encoder.
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] length;
        logic [7:0]       repeats;
    } t_pend;

endpackage

@@ src/dpwg_loader.sv @@
module dpwg_loader (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [7:0]            i_data,
    input  logic                  i_last,
    input  logic [7:0]            i_repeat,
    input  logic                  i_take,
    output dpwg_pkg::t_pend       o_pend,
    output dpwg_pkg::t_buf        o_wait_buf,
    output logic                  o_valid_next,
    output logic                  o_refused
);
    import dpwg_pkg::*;

    logic [IDX_W-1:0] r_fc, n_fc;
    logic             r_ovf, n_ovf;
    logic [7:0]       r_xor, n_xor;
    t_pend            r_pend, n_pend;
    t_buf             r_wbuf;
    logic             wr_data_en;
    logic             wr_sum_en;
    logic [IDX_W-1:0] sum_idx;
    logic [7:0]       sum_val;

    assign sum_idx = r_fc + IDX_W'(1);
    assign sum_val = r_xor ^ i_data;

    always_comb begin
        n_fc       = r_fc;
        n_ovf      = r_ovf;
        n_xor      = r_xor;
        n_pend     = r_pend;
        o_refused  = 1'b0;
        wr_data_en = 1'b0;
        wr_sum_en  = 1'b0;
        if (i_take) begin
            n_pend.valid = 1'b0;
        end
        if (i_load) begin
            if (r_pend.valid) begin
                o_refused = 1'b1;
            end else begin
                if (!r_ovf && r_fc < IDX_W'(MAX_BYTES - 1)) begin
                    wr_data_en = 1'b1;
                    n_xor      = sum_val;
                    n_fc       = sum_idx;
                end else begin
                    n_ovf     = 1'b1;
                    o_refused = 1'b1;
                end
                if (i_last) begin
                    if (n_ovf) begin
                        o_refused = 1'b1;
                    end else begin
                        // append checksum right after the data byte
                        wr_sum_en      = 1'b1;
                        n_pend.length  = LEN_W'(r_fc) + LEN_W'(2);
                        n_pend.repeats = i_repeat;
                        n_pend.valid   = 1'b1;
                    end
                    n_fc  = '0;
                    n_ovf = 1'b0;
                    n_xor = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc   <= '0;
            r_ovf  <= 1'b0;
            r_xor  <= '0;
            r_pend <= '0;
        end else begin
            r_fc   <= n_fc;
            r_ovf  <= n_ovf;
            r_xor  <= n_xor;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (wr_data_en && r_fc == IDX_W'(i)) begin
                r_wbuf[i] <= i_data;
            end
            if (wr_sum_en && sum_idx == IDX_W'(i)) begin
                r_wbuf[i] <= sum_val;
            end
        end
    end

    assign o_pend       = r_pend;
    assign o_wait_buf   = r_wbuf;
    assign o_valid_next = n_pend.valid;

endmodule

@@ src/dpwg_bit_encoder.sv @@
module dpwg_bit_encoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tick,
    input  logic [dpwg_pkg::PRE_W-1:0]   i_preamble_count,
    input  logic [dpwg_pkg::FILL_W-1:0]  i_filler,
    input  dpwg_pkg::t_pend              i_pend,
    input  dpwg_pkg::t_buf               i_wait_buf,
    output logic                         o_take,
    output logic                         o_level_next
);
    import dpwg_pkg::*;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_MID   = 2'd1,
        PH_LOW   = 2'd2,
        PH_END   = 2'd3
    } t_phase;

    t_phase           r_phase, n_phase;
    logic             r_level, n_level;
    logic             r_bit, n_bit;
    logic [PRE_W-1:0] r_pre_left, n_pre_left;
    logic [3:0]       r_bit_idx, n_bit_idx;
    logic [LEN_W-1:0] r_byte_idx, n_byte_idx;
    t_buf             r_buf, n_buf;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_reps, n_reps;

    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       cur_byte;
    logic [2:0]       bit_sel;
    logic [LEN_W:0]   byte_inc;

    assign rd_idx   = (r_byte_idx < LEN_W'(MAX_BYTES)) ? r_byte_idx[IDX_W-1:0] : '0;
    assign cur_byte = r_buf[rd_idx];
    // bit slot 1 carries the MSB
    assign bit_sel  = 3'(LAST_BIT_IDX - r_bit_idx);
    assign byte_inc = {1'b0, r_byte_idx} + (LEN_W+1)'(1);

    always_comb begin
        n_phase    = r_phase;
        n_level    = r_level;
        n_bit      = r_bit;
        n_pre_left = r_pre_left;
        n_bit_idx  = r_bit_idx;
        n_byte_idx = r_byte_idx;
        n_buf      = r_buf;
        n_len      = r_len;
        n_reps     = r_reps;
        o_take     = 1'b0;
        if (i_tick) begin
            unique case (r_phase)
                PH_START: begin
                    n_level = 1'b1;
                    n_phase = PH_MID;
                    if (r_pre_left != '0) begin
                        n_bit      = 1'b1;
                        n_pre_left = r_pre_left - PRE_W'(1);
                    end else begin
                        if (r_bit_idx == '0 || r_bit_idx > LAST_BIT_IDX) begin
                            n_bit = 1'b0;
                        end else begin
                            n_bit = cur_byte[bit_sel];
                        end
                        n_bit_idx = r_bit_idx + 4'd1;
                        if (r_bit_idx >= LAST_BIT_IDX) begin
                            n_bit_idx  = '0;
                            n_byte_idx = byte_inc[LEN_W-1:0];
                            if (byte_inc >= {1'b0, r_len}) begin
                                // end of packet: repeat, swap in pending, or send filler
                                n_byte_idx = '0;
                                n_pre_left = i_preamble_count;
                                if (r_reps != '0) begin
                                    n_reps = r_reps - 8'd1;
                                end else if (i_pend.valid) begin
                                    n_buf  = i_wait_buf;
                                    n_len  = i_pend.length;
                                    n_reps = i_pend.repeats;
                                    o_take = 1'b1;
                                end else begin
                                    n_buf[0] = i_filler[23:16];
                                    n_buf[1] = i_filler[15:8];
                                    n_buf[2] = i_filler[7:0];
                                    n_len    = FILLER_LEN;
                                    n_reps   = '0;
                                end
                            end
                        end
                    end
                end
                PH_MID: begin
                    if (r_bit) begin
                        n_level = 1'b0;
                        n_phase = PH_START;
                    end else begin
                        n_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    n_level = 1'b0;
                    n_phase = PH_END;
                end
                PH_END: begin
                    n_phase = PH_START;
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_level    <= 1'b0;
            r_bit      <= 1'b0;
            r_pre_left <= PREAMBLE_RST;
            r_bit_idx  <= '0;
            r_byte_idx <= '0;
            r_buf      <= SEND_BUF_RST;
            r_len      <= FILLER_LEN;
            r_reps     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_level    <= n_level;
            r_bit      <= n_bit;
            r_pre_left <= n_pre_left;
            r_bit_idx  <= n_bit_idx;
            r_byte_idx <= n_byte_idx;
            r_buf      <= n_buf;
            r_len      <= n_len;
            r_reps     <= n_reps;
        end
    end

    assign o_level_next = n_level;

endmodule

@@ src/dcc_packet_waveform_generator_unit.sv @@
// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready tdata, tlast, tuser
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready tdata
// cfg       in   i_cfg_we (no handshake back)      i_cfg_index, i_cfg_wdata
//
// One transaction per clock: each input item is processed in the cycle it is
// accepted, and its result sits in the output register on the next cycle.
// Throughput is set by the single output register; it refills in the same
// cycle it drains. A stalled output holds its result and stops input.
// Reset (synchronous, active low) starts on the filler packet, full preamble.
module dcc_packet_waveform_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [7:0] data_byte, [15:8] repeat_count
    input  logic        i_s_axis_tlast,  // last_byte
    input  logic        i_s_axis_tuser,  // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [0] track_signal, [1] pending_full,
                                         // [2] load_refused, [7:3] zero
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_wdata
);
    import dpwg_pkg::*;

    logic [PRE_W-1:0]  r_pre_cfg;
    logic [FILL_W-1:0] r_fill_cfg;
    logic              r_m_valid;
    logic [7:0]        r_m_data;

    logic   accept;
    logic   is_tick;
    logic   is_load;
    logic   take;
    logic   level_next;
    logic   valid_next;
    logic   refused;
    t_pend  pend;
    t_buf   wait_buf;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign is_tick = accept && (t_op'(i_s_axis_tuser) == OP_TICK);
    assign is_load = accept && (t_op'(i_s_axis_tuser) == OP_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_cfg  <= PREAMBLE_RST;
            r_fill_cfg <= FILLER_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PREAMBLE: r_pre_cfg  <= i_cfg_wdata[PRE_W-1:0];
                CFG_FILLER:   r_fill_cfg <= i_cfg_wdata[FILL_W-1:0];
                default:      r_pre_cfg  <= r_pre_cfg;
            endcase
        end
    end

    dpwg_bit_encoder u_enc (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick           (is_tick),
        .i_preamble_count (r_pre_cfg),
        .i_filler         (r_fill_cfg),
        .i_pend           (pend),
        .i_wait_buf       (wait_buf),
        .o_take           (take),
        .o_level_next     (level_next)
    );

    dpwg_loader u_load (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (is_load),
        .i_data       (i_s_axis_tdata[7:0]),
        .i_last       (i_s_axis_tlast),
        .i_repeat     (i_s_axis_tdata[15:8]),
        .i_take       (take),
        .o_pend       (pend),
        .o_wait_buf   (wait_buf),
        .o_valid_next (valid_next),
        .o_refused    (refused)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_data <= {5'b0, refused, valid_next, level_next};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

@@ src/dpwg_checker.sv @@
`include "assert_macros.svh"

module dpwg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tlast,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata
);
    import dpwg_pkg::*;

    logic s_acc;
    logic out_stall;
    logic s_tick;
    logic s_last_load;
    assign s_acc       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall   = o_m_axis_tvalid && !i_m_axis_tready;
    assign s_tick      = s_acc && (t_op'(i_s_axis_tuser) == OP_TICK);
    assign s_last_load = s_acc && (t_op'(i_s_axis_tuser) == OP_LOAD) && i_s_axis_tlast;

    // stalled result holds
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // every accepted item yields a result next cycle
    `AST_NEXT(a_one_result, i_clk, i_rst_n, s_acc, o_m_axis_tvalid)

    // a full output register with a stalled sink blocks input
    `AST_SAME(a_no_overrun, i_clk, i_rst_n, out_stall, !o_s_axis_tready)

    // ticks never report a refused load
    `AST_NEXT(a_tick_no_refuse, i_clk, i_rst_n, s_tick, !o_m_axis_tdata[2])

    // a closing load either completes a pending packet or is refused
    `AST_NEXT(a_last_load, i_clk, i_rst_n, s_last_load, o_m_axis_tdata[1] || o_m_axis_tdata[2])

endmodule

bind dcc_packet_waveform_generator_unit dpwg_checker u_dpwg_checker (.*);

@@ dv/tb_dcc_packet_waveform_generator_unit.sv @@
module tb_dcc_packet_waveform_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dpwg_pkg::*;

    localparam int LONG_HOLD_CYCLES = 120;
    localparam int RUN_LIMIT_NS     = 5_000_000;

    typedef enum logic [1:0] {
        PH_RISE     = 2'd0,
        PH_MID      = 2'd1,
        PH_ZERO_LOW = 2'd2,
        PH_ZERO_END = 2'd3
    } timer_phase_t;

    typedef struct packed {
        logic track;
        logic pending;
        logic refused;
    } track_status_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;  // [7:0] data_byte, [15:8] repeat_count
    logic        i_s_axis_tlast;  // last_byte
    logic        i_s_axis_tuser;  // operation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;  // [0] track_signal, [1] pending_full, [2] load_refused
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [23:0] i_cfg_wdata;

    dcc_packet_waveform_generator_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Encoder and packet assembler state, mirrored on the testbench side
    logic [PRE_W-1:0]  reg_preamble;
    logic [FILL_W-1:0] reg_filler;
    timer_phase_t      enc_phase;
    logic              enc_level;
    logic              enc_bit;
    logic [6:0]        enc_pre_left;
    logic [3:0]        enc_bit_pos;
    logic [3:0]        enc_byte_pos;
    logic [7:0]        tx_bytes [MAX_BYTES];
    logic [LEN_W-1:0]  tx_len;
    logic [7:0]        tx_reps;
    logic [7:0]        pend_bytes [MAX_BYTES];
    logic [LEN_W-1:0]  pend_len;
    logic [7:0]        pend_reps;
    logic              pend_full;
    logic [3:0]        asm_count;
    logic              asm_overflow;
    logic [7:0]        asm_xor;

    track_status_t status_q[$];
    int  fail_count     = 0;
    int  items_sent     = 0;
    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    bit  long_hold_armed = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    function automatic void load_filler_packet();
        tx_bytes[0] = reg_filler[23:16];
        tx_bytes[1] = reg_filler[15:8];
        tx_bytes[2] = reg_filler[7:0];
        tx_len      = FILLER_LEN;
        tx_reps     = '0;
    endfunction

    function automatic void encoder_reset();
        reg_preamble = PREAMBLE_RST;
        reg_filler   = FILLER_RST;
        enc_phase    = PH_RISE;
        enc_level    = 1'b0;
        enc_bit      = 1'b0;
        enc_pre_left = reg_preamble;
        enc_bit_pos  = '0;
        enc_byte_pos = '0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            tx_bytes[i]   = '0;
            pend_bytes[i] = '0;
        end
        load_filler_packet();
        pend_len     = '0;
        pend_reps    = '0;
        pend_full    = 1'b0;
        asm_count    = '0;
        asm_overflow = 1'b0;
        asm_xor      = '0;
    endfunction

    function automatic void encoder_next_bit();
        logic [3:0] sel;
        if (enc_pre_left != 0) begin
            enc_bit = 1'b1;
            enc_pre_left--;
            return;
        end
        sel = (enc_byte_pos < MAX_BYTES) ? enc_byte_pos : 4'd0;
        // slot 0 is the start bit, slots 1..8 carry the byte MSB first
        if (enc_bit_pos == 0 || enc_bit_pos > LAST_BIT_IDX) begin
            enc_bit = 1'b0;
        end else begin
            enc_bit = tx_bytes[sel][LAST_BIT_IDX - enc_bit_pos];
        end
        enc_bit_pos++;
        if (enc_bit_pos > LAST_BIT_IDX) begin
            enc_bit_pos = '0;
            enc_byte_pos++;
            if (enc_byte_pos >= tx_len) begin
                enc_byte_pos = '0;
                enc_pre_left = reg_preamble;
                if (tx_reps != 0) begin
                    tx_reps--;
                end else if (pend_full) begin
                    for (int i = 0; i < pend_len; i++) tx_bytes[i] = pend_bytes[i];
                    tx_len    = pend_len;
                    tx_reps   = pend_reps;
                    pend_full = 1'b0;
                end else begin
                    load_filler_packet();
                end
            end
        end
    endfunction

    function automatic track_status_t predict_track_status(input t_op op,
                                                           input logic [7:0] data,
                                                           input logic last,
                                                           input logic [7:0] reps);
        track_status_t r;
        logic          refused;
        refused = 1'b0;
        if (op == OP_TICK) begin
            case (enc_phase)
                PH_RISE: begin
                    enc_level = 1'b1;
                    enc_phase = PH_MID;
                    encoder_next_bit();
                end
                PH_MID: begin
                    if (enc_bit) begin
                        enc_level = 1'b0;
                        enc_phase = PH_RISE;
                    end else begin
                        enc_phase = PH_ZERO_LOW;
                    end
                end
                PH_ZERO_LOW: begin
                    enc_level = 1'b0;
                    enc_phase = PH_ZERO_END;
                end
                default: enc_phase = PH_RISE;
            endcase
        end else if (pend_full) begin
            // drop the byte, keep the fill progress
            refused = 1'b1;
        end else begin
            if (!asm_overflow && asm_count < MAX_BYTES - 1) begin
                pend_bytes[asm_count] = data;
                asm_xor ^= data;
                asm_count++;
            end else begin
                asm_overflow = 1'b1;
                refused      = 1'b1;
            end
            if (last) begin
                if (asm_overflow) begin
                    refused = 1'b1;
                end else begin
                    pend_bytes[asm_count] = asm_xor;
                    pend_len  = asm_count + 1'b1;
                    pend_reps = reps;
                    pend_full = 1'b1;
                end
                asm_count    = '0;
                asm_overflow = 1'b0;
                asm_xor      = '0;
            end
        end
        r.track   = enc_level;
        r.pending = pend_full;
        r.refused = refused;
        return r;
    endfunction

    task automatic send_item(input t_op op, input logic [7:0] data, input logic last,
                             input logic [7:0] reps);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {reps, data};
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        status_q.push_back(predict_track_status(op, data, last, reps));
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        // fields other than the operation are don't-care on a tick: randomize them
        for (int i = 0; i < n; i++) send_item(OP_TICK, 8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic send_packet(input int len, input logic [7:0] reps);
        for (int i = 0; i < len; i++) begin
            send_item(OP_LOAD, 8'($urandom), (i == len - 1),
                      (i == len - 1) ? reps : 8'($urandom));
        end
    endtask

    task automatic tick_until_taken(input int max_ticks);
        for (int n = 0; n < max_ticks && pend_full; n++) send_ticks(1);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (idx == CFG_PREAMBLE) reg_preamble = value[PRE_W-1:0];
        else reg_filler = value[FILL_W-1:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] want_v,
                                   input logic [7:0] got_v);
        fail_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : check_results
        track_status_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (status_q.size() == 0) begin
                report_mismatch("unexpected transaction", 8'h00, o_m_axis_tdata);
            end else begin
                want = status_q.pop_front();
                if (o_m_axis_tdata[0] !== want.track)
                    report_mismatch("track_signal", want.track, o_m_axis_tdata[0]);
                if (o_m_axis_tdata[1] !== want.pending)
                    report_mismatch("pending_full", want.pending, o_m_axis_tdata[1]);
                if (o_m_axis_tdata[2] !== want.refused)
                    report_mismatch("load_refused", want.refused, o_m_axis_tdata[2]);
                if (o_m_axis_tdata[7:3] !== 5'd0)
                    report_mismatch("pad bits", 8'h00, o_m_axis_tdata[7:3]);
            end
        end
    end

    // Output side: random stalls, plus one long hold-off on request
    initial begin
        int k;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_armed) begin
                i_m_axis_tready <= 1'b0;
                for (k = 0; k < LONG_HOLD_CYCLES; k++) @(posedge i_clk);
                long_hold_armed = 1'b0;
            end
            i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic test_default_waveform();
        set_idling(0, 0);
        send_ticks(40);
    endtask

    task automatic test_load_and_refuse();
        write_reg(CFG_PREAMBLE, 24'd2);
        send_item(OP_LOAD, 8'hFF, 1'b0, 8'h00);
        send_item(OP_LOAD, 8'h00, 1'b1, 8'd1);
        // pending is full now: drop both a middle byte and a closing byte
        send_item(OP_LOAD, 8'hA5, 1'b0, 8'hFF);
        send_item(OP_LOAD, 8'h5A, 1'b1, 8'hFF);
        tick_until_taken(3000);
        send_packet(1, 8'd0);
        tick_until_taken(3000);
        send_ticks(20);
    endtask

    task automatic test_overlong_packet();
        send_packet(MAX_BYTES + 1, 8'd0);
        send_packet(MAX_BYTES - 1, 8'd0);
        tick_until_taken(3000);
        send_ticks(20);
    endtask

    task automatic test_filler_update();
        write_reg(CFG_FILLER, 24'h000000);
        send_ticks(120);
        write_reg(CFG_FILLER, 24'hFFFFFF);
        send_ticks(100);
    endtask

    task automatic test_preamble_extremes();
        write_reg(CFG_PREAMBLE, 24'd0);
        send_ticks(100);
        write_reg(CFG_PREAMBLE, 24'd127);
        send_ticks(340);
        write_reg(CFG_PREAMBLE, 24'd64);
        send_ticks(60);
    endtask

    task automatic test_output_backpressure();
        write_reg(CFG_PREAMBLE, 24'd2);
        set_idling(0, 0);
        long_hold_armed = 1'b1;
        send_ticks(10);
        send_packet(3, 8'd0);
        send_ticks(30);
        wait_drained();
    endtask

    task automatic random_traffic(input int n);
        int          start;
        int          choice;
        int          len;
        logic [7:0]  reps;
        start = items_sent;
        while (items_sent - start < n) begin
            choice = $urandom_range(0, 99);
            if (choice < 14) begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_BYTES, MAX_BYTES + 2)
                                                   : $urandom_range(1, MAX_BYTES - 1);
                reps = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(3, 8))
                                                   : 8'($urandom_range(0, 2));
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 3) == 0) send_ticks($urandom_range(1, 3));
                    send_item(OP_LOAD, 8'($urandom), (i == len - 1),
                              (i == len - 1) ? reps : 8'($urandom));
                end
            end else if (choice < 18) begin
                // stray load with random framing
                send_item(OP_LOAD, 8'($urandom), 1'($urandom), 8'($urandom));
            end else if (choice < 19) begin
                wait_drained();
            end else begin
                send_ticks($urandom_range(1, 12));
            end
        end
    endtask

    task automatic test_random_traffic();
        set_idling(0, 0);
        write_reg(CFG_PREAMBLE, 24'd2);
        write_reg(CFG_FILLER, 24'($urandom));
        random_traffic(70);
        set_idling(68, 0);
        write_reg(CFG_PREAMBLE, 24'd5);
        random_traffic(60);
        set_idling(0, 68);
        write_reg(CFG_PREAMBLE, 24'd64);
        write_reg(CFG_FILLER, 24'($urandom));
        random_traffic(60);
        set_idling(8, 8);
        write_reg(CFG_PREAMBLE, 24'($urandom_range(2, 16)));
        write_reg(CFG_FILLER, 24'($urandom));
        random_traffic(60);
    endtask

    task automatic test_long_repeat();
        set_idling(0, 0);
        write_reg(CFG_PREAMBLE, 24'd2);
        tick_until_taken(6000);
        send_item(OP_LOAD, 8'h3C, 1'b1, 8'd255);
        tick_until_taken(6000);
        send_ticks(50);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_s_axis_tuser  <= OP_TICK;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_PREAMBLE;
        i_cfg_wdata     <= '0;
        encoder_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_waveform();
        test_load_and_refuse();
        test_overlong_packet();
        test_filler_update();
        test_preamble_extremes();
        test_output_backpressure();
        test_random_traffic();
        test_long_repeat();

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && status_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
